// ===== design/ecdd_pkg.sv =====
// shared constants, types and codes of the edge-chasing deadlock detector
package ecdd_pkg;

   // sizes
   localparam int NODES      = 8;
   localparam int NODE_BITS  = $clog2(NODES);
   localparam int LABEL_BITS = 16;
   localparam int CFG_BITS   = 4;

   localparam logic [LABEL_BITS-1:0] LABEL_TOP        = {LABEL_BITS{1'b1}};
   localparam logic [CFG_BITS-1:0]   NODE_COUNT_RESET = CFG_BITS'(8);
   localparam logic [NODE_BITS-1:0]  NODE_LAST        = NODE_BITS'(NODES - 1);

   // controller states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_BUMP   = 7'b0000100,
      ST_SPREAD = 7'b0001000,
      ST_ROW    = 7'b0010000,
      ST_SCAN   = 7'b0100000,
      ST_FLUSH  = 7'b1000000
   } ecdd_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic                 capture;
      logic                 load_top;
      logic                 bump;
      logic                 spread;
      logic                 load_row;
      logic                 scan;
      logic                 flush;
      logic [NODE_BITS-1:0] rd_addr;
      logic [NODE_BITS-1:0] row_addr;
   } ecdd_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic                 in_range;
      logic [NODE_BITS-1:0] edge_a;
      logic [NODE_BITS-1:0] edge_b;
      logic                 spread_change;
      logic                 row_ok;
      logic                 hold_valid;
      logic                 out_free;
   } ecdd_status_type;

endpackage

// ===== design/ecdd_ctrl.sv =====
// controller state machine: edge update, label spreading sweeps, edge scan
module ecdd_ctrl
   import ecdd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ecdd_status_type status,
   output ecdd_cmd_type    cmd
);

   ecdd_state_type       state_ff, state_in;
   logic [NODE_BITS-1:0] col_ff, col_in;
   logic [NODE_BITS-1:0] row_ff, row_in;
   logic                 changed_ff, changed_in;

   // only idle takes a new transfer
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      changed_in = changed_ff;
      cmd        = '0;
      cmd.row_addr = row_ff;
      cmd.rd_addr  = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // edges touching nodes beyond the count are dropped
            if (!status.in_range) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_addr  = status.edge_a;
               cmd.load_top = 1'b1;
               state_in     = ST_BUMP;
            end
         end
         ST_BUMP: begin
            cmd.rd_addr = status.edge_b;
            cmd.bump    = 1'b1;
            col_in      = '0;
            changed_in  = 1'b0;
            state_in    = ST_SPREAD;
         end
         ST_SPREAD: begin
            // one column per cycle, sweeps repeat until a sweep changes nothing
            cmd.spread = 1'b1;
            if (col_ff == NODE_LAST) begin
               col_in = '0;
               if (changed_ff || status.spread_change) begin
                  changed_in = 1'b0;
               end else begin
                  row_in   = '0;
                  state_in = ST_ROW;
               end
            end else begin
               col_in     = col_ff + 1'b1;
               changed_in = changed_ff | status.spread_change;
            end
         end
         ST_ROW: begin
            cmd.rd_addr  = row_ff;
            cmd.load_row = 1'b1;
            if (status.row_ok) begin
               col_in   = '0;
               state_in = ST_SCAN;
            end else if (row_ff == NODE_LAST) begin
               state_in = ST_FLUSH;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (status.out_free) begin
               cmd.scan = 1'b1;
               if (col_ff == NODE_LAST) begin
                  if (row_ff == NODE_LAST) begin
                     state_in = ST_FLUSH;
                  end else begin
                     row_in   = row_ff + 1'b1;
                     state_in = ST_ROW;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            // held report goes out marked last
            if (!status.hold_valid || status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         col_ff     <= '0;
         row_ff     <= '0;
         changed_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         changed_ff <= changed_in;
      end
   end

endmodule

// ===== design/ecdd_dpath.sv =====
// datapath: labels, blocked-by matrix, node count, report hold and output register
module ecdd_dpath
   import ecdd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [NODE_BITS-1:0] req_blocked_node,
   input  logic [NODE_BITS-1:0] req_blocking_node,
   input  logic                 csr_write_enable,
   input  logic [CFG_BITS-1:0]  csr_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [NODE_BITS-1:0] rsp_deadlocked_node,
   output logic [NODE_BITS-1:0] rsp_partner_node,
   output logic                 rsp_last,
   input  ecdd_cmd_type         cmd,
   output ecdd_status_type      status
);

   logic [CFG_BITS-1:0]   node_count_ff, node_count_in;
   logic [CFG_BITS-1:0]   count_eff;
   logic [NODES-1:0]      active;

   logic [LABEL_BITS-1:0] pub_ff  [NODES];
   logic [LABEL_BITS-1:0] pub_in  [NODES];
   logic [LABEL_BITS-1:0] priv_ff [NODES];
   logic [LABEL_BITS-1:0] priv_in [NODES];
   logic [NODES-1:0]      adj_ff  [NODES];
   logic [NODES-1:0]      adj_in  [NODES];

   logic [NODE_BITS-1:0]  edge_a_ff, edge_a_in;
   logic [NODE_BITS-1:0]  edge_b_ff, edge_b_in;
   logic [LABEL_BITS-1:0] top_ff, top_in;
   logic [LABEL_BITS-1:0] row_label_ff, row_label_in;
   logic [NODES-1:0]      row_bits_ff, row_bits_in;

   logic                  hold_valid_ff, hold_valid_in;
   logic [NODE_BITS-1:0]  hold_node_ff, hold_node_in;
   logic [NODE_BITS-1:0]  hold_partner_ff, hold_partner_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NODE_BITS-1:0]  rsp_node_ff, rsp_node_in;
   logic [NODE_BITS-1:0]  rsp_partner_ff, rsp_partner_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [LABEL_BITS-1:0] rd_data;
   logic [LABEL_BITS-1:0] top_max;
   logic [LABEL_BITS-1:0] fresh;
   logic                  spread_change;
   logic                  hit;
   logic                  push;
   logic                  push_last;
   logic                  out_free;

   // effective node count and active node mask
   always_comb begin
      if (node_count_ff == '0) begin
         count_eff = CFG_BITS'(1);
      end else if (node_count_ff > CFG_BITS'(NODES)) begin
         count_eff = CFG_BITS'(NODES);
      end else begin
         count_eff = node_count_ff;
      end
      for (int k = 0; k < NODES; k++) begin
         active[k] = (CFG_BITS'(k) < count_eff);
      end
   end

   assign node_count_in = csr_write_enable ? csr_write_data : node_count_ff;

   // addressed public label read port
   assign rd_data = pub_ff[cmd.rd_addr];

   // new label of the blocked node, saturating
   assign top_max = (top_ff > rd_data) ? top_ff : rd_data;
   assign fresh   = (top_max == LABEL_TOP) ? LABEL_TOP : top_max + 1'b1;

   // edge capture and scratch registers
   assign edge_a_in    = cmd.capture  ? req_blocked_node  : edge_a_ff;
   assign edge_b_in    = cmd.capture  ? req_blocking_node : edge_b_ff;
   assign top_in       = cmd.load_top ? rd_data : top_ff;
   assign row_label_in = cmd.load_row ? rd_data : row_label_ff;
   assign row_bits_in  = cmd.load_row ? (adj_ff[cmd.rd_addr] & active) : row_bits_ff;

   // label and matrix updates: edge insert, column spread
   always_comb begin
      pub_in        = pub_ff;
      priv_in       = priv_ff;
      adj_in        = adj_ff;
      spread_change = 1'b0;
      if (cmd.bump) begin
         pub_in[edge_a_ff]            = fresh;
         priv_in[edge_a_ff]           = fresh;
         adj_in[edge_a_ff][edge_b_ff] = 1'b1;
      end
      if (cmd.spread) begin
         for (int i = 0; i < NODES; i++) begin
            if (active[i] && active[cmd.rd_addr] && adj_ff[i][cmd.rd_addr] &&
                (rd_data > pub_ff[i])) begin
               pub_in[i]     = rd_data;
               spread_change = 1'b1;
            end
         end
      end
   end

   // edge test during the scan
   assign hit      = row_bits_ff[cmd.rd_addr] && (row_label_ff == rd_data);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // one report held back so the final one can be marked last
   always_comb begin
      push            = 1'b0;
      push_last       = 1'b0;
      hold_valid_in   = hold_valid_ff;
      hold_node_in    = hold_node_ff;
      hold_partner_in = hold_partner_ff;
      if (cmd.scan && hit) begin
         push            = hold_valid_ff;
         hold_valid_in   = 1'b1;
         hold_node_in    = cmd.row_addr;
         hold_partner_in = cmd.rd_addr;
      end
      if (cmd.flush && hold_valid_ff) begin
         push          = 1'b1;
         push_last     = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   // output register
   assign rsp_valid_in   = push | (rsp_valid_ff & rsp_stall);
   assign rsp_node_in    = push ? hold_node_ff    : rsp_node_ff;
   assign rsp_partner_in = push ? hold_partner_ff : rsp_partner_ff;
   assign rsp_last_in    = push ? push_last       : rsp_last_ff;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < NODES; k++) begin
            pub_ff[k]  <= LABEL_BITS'(k);
            priv_ff[k] <= LABEL_BITS'(k);
            adj_ff[k]  <= '0;
         end
      end else begin
         node_count_ff <= node_count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pub_ff        <= pub_in;
         priv_ff       <= priv_in;
         adj_ff        <= adj_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      edge_a_ff       <= edge_a_in;
      edge_b_ff       <= edge_b_in;
      top_ff          <= top_in;
      row_label_ff    <= row_label_in;
      row_bits_ff     <= row_bits_in;
      hold_node_ff    <= hold_node_in;
      hold_partner_ff <= hold_partner_in;
      rsp_node_ff     <= rsp_node_in;
      rsp_partner_ff  <= rsp_partner_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // status
   always_comb begin
      status               = '0;
      status.in_range      = active[edge_a_ff] && active[edge_b_ff];
      status.edge_a        = edge_a_ff;
      status.edge_b        = edge_b_ff;
      status.spread_change = spread_change;
      status.row_ok        = active[cmd.rd_addr] &&
                             (priv_ff[cmd.rd_addr] == pub_ff[cmd.rd_addr]) &&
                             (|(adj_ff[cmd.rd_addr] & active));
      status.hold_valid    = hold_valid_ff;
      status.out_free      = out_free;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_deadlocked_node = rsp_node_ff;
   assign rsp_partner_node    = rsp_partner_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

// ===== design/edge_chasing_deadlock_detector_core.sv =====
// edge-chasing deadlock detector: top level joining controller and datapath
// per edge: the edge is taken, checked and inserted, then labels spread in column sweeps
//   that repeat until a sweep changes nothing, then each row is tested, a row that can hold
//   a deadlock is scanned column by column, and the held report is flushed
// one edge at a time, a stalled result holds the scan; an out-of-range edge is dropped at the check
// synchronous reset: labels to node index, matrix empty, node count 8, output empty
module edge_chasing_deadlock_detector_core
   import ecdd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NODE_BITS-1:0] req_blocked_node,
   input  logic [NODE_BITS-1:0] req_blocking_node,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [NODE_BITS-1:0] rsp_deadlocked_node,
   output logic [NODE_BITS-1:0] rsp_partner_node,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [CFG_BITS-1:0]  csr_write_data
);

   ecdd_cmd_type    cmd;
   ecdd_status_type status;

   // sequencing
   ecdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   ecdd_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_blocked_node    (req_blocked_node),
      .req_blocking_node   (req_blocking_node),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_deadlocked_node (rsp_deadlocked_node),
      .rsp_partner_node    (rsp_partner_node),
      .rsp_last            (rsp_last),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

// ===== design/ecdd_checker.sv =====
// port-level checks of the deadlock detector, bound to the top level
module ecdd_props
   import ecdd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [NODE_BITS-1:0] rsp_deadlocked_node,
   input logic [NODE_BITS-1:0] rsp_partner_node,
   input logic                 rsp_last
);

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an accepted edge keeps the block busy in the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("new edge taken while previous one still in work");

   // while a non-final report waits, the item is unfinished
   a_busy_midstream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("block idle with a non-final report pending");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_deadlocked_node) &&
         $stable(rsp_partner_node) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind edge_chasing_deadlock_detector_core ecdd_props u_ecdd_props (.*);

// ===== verif/ecdd_checker.sv =====
// checker for the deadlock detector: label predictor, report queue and comparison
`timescale 1ns / 100ps

module ecdd_checker
   import ecdd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [NODE_BITS-1:0] req_blocked_node,
   input  logic [NODE_BITS-1:0] req_blocking_node,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [NODE_BITS-1:0] rsp_deadlocked_node,
   input  logic [NODE_BITS-1:0] rsp_partner_node,
   input  logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [CFG_BITS-1:0]  csr_write_data,
   output int                   fail_count,
   output int                   reports_due,
   output int                   edges_taken,
   output int                   reports_seen
);

   localparam int REPORT_CAP = 64;

   typedef struct packed {
      logic [NODE_BITS-1:0] deadlocked;
      logic [NODE_BITS-1:0] partner;
      logic                 last;
   } deadlock_report_type;

   deadlock_report_type   due_reports[$];
   logic [LABEL_BITS-1:0] public_lbl [NODES];
   logic [LABEL_BITS-1:0] private_lbl [NODES];
   logic [NODES-1:0]      waits_on [NODES];
   logic [CFG_BITS-1:0]   node_count;
   int                    mismatches;
   int                    edge_total;
   int                    report_total;

   // reset labels, wait-for edges and node count, and clear the report queue
   task automatic clear_model();
      for (int k = 0; k < NODES; k++) begin
         public_lbl[k]  = LABEL_BITS'(k);
         private_lbl[k] = LABEL_BITS'(k);
         waits_on[k]    = '0;
      end
      node_count = NODE_COUNT_RESET;
      due_reports.delete();
   endtask

   // apply one wait edge, spread labels and queue the deadlock reports it causes
   task automatic chase_edge(input logic [NODE_BITS-1:0] blocked,
                             input logic [NODE_BITS-1:0] blocking);
      int                    live;
      int                    found;
      bit                    moved;
      bit                    have_prev;
      logic [LABEL_BITS-1:0] top;
      deadlock_report_type   prev;
      live = (node_count == 0) ? 1 : ((node_count > NODES) ? NODES : int'(node_count));
      if (blocked >= live || blocking >= live) return;

      // new label for the blocked node, saturating
      top = (public_lbl[blocked] > public_lbl[blocking]) ?
            public_lbl[blocked] : public_lbl[blocking];
      top = (top == LABEL_TOP) ? LABEL_TOP : top + 1'b1;
      public_lbl[blocked]  = top;
      private_lbl[blocked] = top;
      waits_on[blocked][blocking] = 1'b1;

      // push public labels back along wait edges until stable
      for (int pass = 0; pass <= NODES; pass++) begin
         moved = 1'b0;
         for (int i = 0; i < live; i++)
            for (int j = 0; j < live; j++)
               if (waits_on[i][j] && public_lbl[j] > public_lbl[i]) begin
                  public_lbl[i] = public_lbl[j];
                  moved = 1'b1;
               end
         if (!moved) break;
      end

      // detection scan; the final report of the batch carries last
      found = 0;
      have_prev = 1'b0;
      for (int i = 0; i < live; i++)
         for (int j = 0; j < live; j++)
            if (waits_on[i][j] && private_lbl[i] == public_lbl[i] &&
                public_lbl[i] == public_lbl[j] && found < REPORT_CAP) begin
               if (have_prev) due_reports = {due_reports, prev};
               prev = '{deadlocked: NODE_BITS'(i), partner: NODE_BITS'(j), last: 1'b0};
               have_prev = 1'b1;
               found++;
            end
      if (have_prev) begin
         prev.last = 1'b1;
         due_reports = {due_reports, prev};
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   initial clear_model();

   // sample all channels at the clock edge
   always @(posedge clock) begin
      deadlock_report_type want;
      if (reset) begin
         clear_model();
      end else begin
         // result transfer, checked before a same-cycle input is predicted
         if (rsp_valid && !rsp_stall) begin
            report_total++;
            if (due_reports.size() == 0) begin
               $display("%0t: unexpected report, expected none, actual node %0d partner %0d last %0d",
                        $time, rsp_deadlocked_node, rsp_partner_node, rsp_last);
               mismatches++;
            end else begin
               want = due_reports.pop_front();
               check_field("deadlocked_node", want.deadlocked, rsp_deadlocked_node);
               check_field("partner_node", want.partner, rsp_partner_node);
               check_field("last", want.last, rsp_last);
            end
         end
         // input transfer
         if (req_valid && !req_stall) begin
            edge_total++;
            chase_edge(req_blocked_node, req_blocking_node);
         end
         // node count write
         if (csr_write_enable) node_count = csr_write_data;
      end
      fail_count   <= mismatches;
      reports_due  <= due_reports.size();
      edges_taken  <= edge_total;
      reports_seen <= report_total;
   end

endmodule

// ===== verif/edge_chasing_deadlock_detector_core_tb.sv =====
// testbench top for the deadlock detector: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module edge_chasing_deadlock_detector_core_tb;
   import ecdd_pkg::*;

   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 600;
   localparam int CYCLE_LIMIT   = 1000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [NODE_BITS-1:0] req_blocked_node = '0;
   logic [NODE_BITS-1:0] req_blocking_node = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [NODE_BITS-1:0] rsp_deadlocked_node;
   logic [NODE_BITS-1:0] rsp_partner_node;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic [CFG_BITS-1:0]  csr_write_data = '0;

   int fail_count;
   int reports_due;
   int edges_taken;
   int reports_seen;
   int cycles = 0;
   bit calm = 1'b0;
   bit long_hold = 1'b0;

   edge_chasing_deadlock_detector_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_blocked_node    (req_blocked_node),
      .req_blocking_node   (req_blocking_node),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_deadlocked_node (rsp_deadlocked_node),
      .rsp_partner_node    (rsp_partner_node),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   ecdd_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_blocked_node    (req_blocked_node),
      .req_blocking_node   (req_blocking_node),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_deadlocked_node (rsp_deadlocked_node),
      .rsp_partner_node    (rsp_partner_node),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .fail_count          (fail_count),
      .reports_due         (reports_due),
      .edges_taken         (edges_taken),
      .reports_seen        (reports_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one wait edge, sometimes after a gap, and hold it until the transfer
   task automatic send_edge(input logic [NODE_BITS-1:0] blocked,
                            input logic [NODE_BITS-1:0] blocking);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_blocked_node  <= blocked;
      req_blocking_node <= blocking;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering, wait for every report, then let ignored edges finish
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [CFG_BITS-1:0] value);
      drain_and_settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly in-range nodes, some anywhere in the field
   function automatic logic [NODE_BITS-1:0] pick_node(input int live);
      if ($urandom_range(0, 7) == 0) return NODE_BITS'($urandom_range(0, NODES - 1));
      return NODE_BITS'($urandom_range(0, live - 1));
   endfunction

   task automatic random_edges(input int count, input int live);
      logic [NODE_BITS-1:0] blocked;
      logic [NODE_BITS-1:0] blocking;
      for (int k = 0; k < count; k++) begin
         blocked  = pick_node(live);
         blocking = pick_node(live);
         send_edge(blocked, blocking);
      end
   endtask

   // receiver: random stall bursts, free stretches, one long hold-off on request
   initial begin
      int   span;
      logic level;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            span  = HOLD_CYCLES;
            level = 1'b1;
         end else if (calm) begin
            span  = 1;
            level = 1'b0;
         end else if ($urandom_range(0, 1) == 0) begin
            span  = $urandom_range(1, 17);
            level = 1'b1;
         end else begin
            span  = $urandom_range(1, 40);
            level = 1'b0;
         end
         repeat (span) begin
            rsp_stall <= level;
            @(posedge clock);
         end
      end
   end

   // run limit
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // stimulus and verdict
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two nodes: a two-node cycle, a duplicate, out-of-range nodes
      write_node_count(4'd2);
      send_edge(3'd0, 3'd1);
      send_edge(3'd1, 3'd0);
      send_edge(3'd0, 3'd1);
      send_edge(3'd2, 3'd0);
      send_edge(3'd0, 3'd3);

      // zero count acts as one node: self edge
      write_node_count(4'd0);
      send_edge(3'd0, 3'd0);
      send_edge(3'd1, 3'd1);
      send_edge(3'd0, 3'd0);

      // count above the node total acts as all nodes
      write_node_count(4'd15);
      send_edge(3'd7, 3'd7);
      send_edge(3'd7, 3'd0);
      send_edge(3'd6, 3'd5);
      send_edge(3'd5, 3'd6);
      send_edge(3'd3, 3'd4);
      send_edge(3'd4, 3'd2);
      send_edge(3'd2, 3'd3);
      send_edge(3'd0, 3'd7);
      send_edge(3'd7, 3'd6);

      // one node again: state kept, higher nodes ignored
      write_node_count(4'd1);
      send_edge(3'd0, 3'd0);
      send_edge(3'd7, 3'd7);
      send_edge(3'd0, 3'd5);

      // random phases over several node counts
      write_node_count(4'd8);
      long_hold = 1'b1;
      random_edges(30, 8);
      write_node_count(4'd4);
      random_edges(25, 4);
      write_node_count(4'd15);
      random_edges(25, 8);
      write_node_count(4'd3);
      random_edges(20, 3);
      write_node_count(4'd1);
      random_edges(10, 1);
      write_node_count(4'd8);
      calm = 1'b1;
      random_edges(20, 8);

      drain_and_settle();
      $display("covered %0d accepted wait edges and %0d deadlock reports", edges_taken,
               reports_seen);
      $display("node counts 0 to 15 written, with random stalls and one long hold-off");
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
